@@ sv/tmab_pkg.sv @@
// tmab_pkg: shared types, codes and constants for the tiled mask alpha blend core.
// No dependencies; imported by the core, the multiplier and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package tmab_pkg;

    // default sizes handed to the top-level parameters
    localparam int MASK_DIM_DEF = 64;
    localparam int MAX_ROW_DEF  = 4096;

    // request field widths
    localparam int MODE_W      = 2;
    localparam int MASK_IDX_W  = 12;
    localparam int MASK_VAL_W  = 8;
    localparam int PIXEL_W     = 32;
    localparam int IN_FIELDS_W = MASK_IDX_W + MASK_VAL_W + 2 * PIXEL_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int MASK_SIZE_W = 7;
    localparam int MASK_OFS_W  = 6;
    localparam int RECT_W      = 13;

    // blend weight is 0..256
    localparam int ALPHA_W = 9;

    localparam logic [PIXEL_W-1:0] LANES_RB     = 32'h00ff_00ff;
    localparam logic [PIXEL_W-1:0] LANES_G      = 32'h0000_ff00;
    localparam logic [PIXEL_W-1:0] ALPHA_FORCED = 32'hff00_0000;
    localparam int                 ALPHA_POS    = 24;
    localparam logic [7:0]         FULL_ALPHA   = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_BLEND   = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_WIDTH  = 3'd0,
        CFG_MASK_HEIGHT = 3'd1,
        CFG_MASK_X0     = 3'd2,
        CFG_MASK_Y0     = 3'd3,
        CFG_RECT_WIDTH  = 3'd4,
        CFG_USE_SRC_A   = 3'd5
    } cfg_idx_t;

    // sequencer: address, alpha, red/blue pair, green
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_ALPHA,
        ST_RB,
        ST_G
    } state_t;

    // operand select of the shared multiplier
    typedef enum logic [1:0] {
        MUL_ADDR,
        MUL_ALPHA,
        MUL_RB,
        MUL_G
    } mul_sel_t;

endpackage

`default_nettype wire

@@ sv/tmab_ram.sv @@
// tmab_ram: generic single-port RAM with registered read.
// No dependencies; holds the mask tile of the blend core.
`timescale 1ns / 1ps
`default_nettype none

module tmab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/tmab_mul.sv @@
// tmab_mul: shared 32x9 multiplier, low 32 bits of the product (wraparound).
// Depends on tmab_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module tmab_mul
    import tmab_pkg::*;
(
    input  wire logic [PIXEL_W-1:0] a,
    input  wire logic [ALPHA_W-1:0] b,
    output logic      [PIXEL_W-1:0] p
);

    always_comb
    begin
        p = a * PIXEL_W'(b);
    end

endmodule

`default_nettype wire

@@ sv/tiled_mask_alpha_blend_core.sv @@
// tiled_mask_alpha_blend_core: ARGB8888 blend of a source stream over destination
// pixels with coverage from a repeating mask tile. Uses tmab_pkg, tmab_ram, tmab_mul.
//
// Channels:
//   s_*   requests. s_tuser = mode (load mask byte, blend pixel, restart walk).
//         s_tdata carries mask_index, mask_value, source pixel, dst_pixel.
//   m_*   one result per blend request: m_tdata = result_pixel, m_tlast = row_end.
//   cfg_* register writes (index, data); always ready, write only while idle.
// Timing:
//   Load, restart and unknown modes finish in the cycle they are accepted.
//   A blend runs after acceptance through one shared multiplier, in steps:
//   tile address (row * width), mask-scaled alpha, red/blue pair, green.
//   The mask RAM read sits between the address and alpha steps. New
//   requests are not taken until a blend has left its last step.
// Output:
//   The result sits in an output register. The next request is taken while it
//   waits; if the receiver still stalls when the next blend finishes, the
//   sequencer holds in its last step until the register frees up.
// Reset:
//   Registers return to width 1, height 1, offsets 0, rect 1, src alpha off;
//   walk position to the tile origin. The mask RAM is not cleared; entries
//   must be loaded before a blend reads them.
`timescale 1ns / 1ps
`default_nettype none

module tiled_mask_alpha_blend_core
    import tmab_pkg::*;
#(
    parameter int MASK_DIM = MASK_DIM_DEF,
    parameter int MAX_ROW  = MAX_ROW_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [11:0] mask_index, [19:12] mask_value, [51:20] source pixel,
    // [83:52] dst_pixel, [87:84] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  wire logic [MODE_W-1:0]     s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] result_pixel
    output logic      [PIXEL_W-1:0]    m_tdata,
    // row_end
    output logic                       m_tlast,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_DEPTH = MASK_DIM * MASK_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W       = (MASK_DIM > 1) ? $clog2(MASK_DIM) : 1;
    localparam int WD_W        = $clog2(MASK_DIM + 1);
    localparam int CNT_W       = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int RW_W        = $clog2(MAX_ROW + 1);

    // ---------------- registers ----------------
    state_t                 state_reg, state_next;

    logic [MASK_SIZE_W-1:0] mask_width_reg, mask_height_reg;
    logic [MASK_OFS_W-1:0]  mask_x0_reg, mask_y0_reg;
    logic [RECT_W-1:0]      rect_width_reg;
    logic                   use_src_alpha_reg;

    logic [COL_W-1:0]       col_reg, col_next;
    logic [COL_W-1:0]       row_reg, row_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [PIXEL_W-1:0]     src_reg, dst_reg;
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [PIXEL_W-1:0]     rb_reg;

    logic                   out_valid_reg;
    logic [PIXEL_W-1:0]     out_pixel_reg;
    logic                   out_last_reg;

    // ---------------- request decode ----------------
    logic                   req_acc;
    mode_t                  req_mode;
    logic [MASK_IDX_W-1:0]  req_idx;
    logic [MASK_VAL_W-1:0]  req_val;
    logic [PIXEL_W-1:0]     req_src, req_dst;

    assign req_acc  = s_tvalid & s_tready;
    assign req_mode = mode_t'(s_tuser);
    assign req_idx  = s_tdata[MASK_IDX_W-1:0];
    assign req_val  = s_tdata[MASK_IDX_W +: MASK_VAL_W];
    assign req_src  = s_tdata[MASK_IDX_W + MASK_VAL_W +: PIXEL_W];
    assign req_dst  = s_tdata[MASK_IDX_W + MASK_VAL_W + PIXEL_W +: PIXEL_W];

    // ---------------- effective sizes ----------------
    logic [WD_W-1:0]  w_eff, h_eff;
    logic [RW_W-1:0]  rw_eff;
    logic [COL_W-1:0] start_col, start_row;
    logic [COL_W-1:0] c_eff, r_eff;

    always_comb
    begin
        if (mask_width_reg == '0)
            w_eff = WD_W'(1);
        else if (32'(mask_width_reg) > 32'(MASK_DIM))
            w_eff = WD_W'(MASK_DIM);
        else
            w_eff = WD_W'(mask_width_reg);

        if (mask_height_reg == '0)
            h_eff = WD_W'(1);
        else if (32'(mask_height_reg) > 32'(MASK_DIM))
            h_eff = WD_W'(MASK_DIM);
        else
            h_eff = WD_W'(mask_height_reg);

        if (rect_width_reg == '0)
            rw_eff = RW_W'(1);
        else if (32'(rect_width_reg) > 32'(MAX_ROW))
            rw_eff = RW_W'(MAX_ROW);
        else
            rw_eff = RW_W'(rect_width_reg);

        // offset outside the tile starts at 0
        start_col = (32'(mask_x0_reg) < 32'(w_eff)) ? COL_W'(mask_x0_reg) : '0;
        start_row = (32'(mask_y0_reg) < 32'(h_eff)) ? COL_W'(mask_y0_reg) : '0;

        // stale position after a size change reads as 0
        c_eff = (32'(col_reg) < 32'(w_eff)) ? col_reg : '0;
        r_eff = (32'(row_reg) < 32'(h_eff)) ? row_reg : '0;
    end

    // ---------------- sequencer outputs ----------------
    mul_sel_t mul_sel;
    logic     ram_rd;
    logic     out_free;
    logic     blend_done;

    assign out_free = ~out_valid_reg | m_tready;

    always_comb
    begin
        mul_sel    = MUL_ADDR;
        ram_rd     = 1'b0;
        blend_done = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_ADDR:
            begin
                mul_sel = MUL_ADDR;
                ram_rd  = 1'b1;
            end
            ST_ALPHA:
            begin
                mul_sel = MUL_ALPHA;
            end
            ST_RB:
            begin
                mul_sel = MUL_RB;
            end
            ST_G:
            begin
                mul_sel    = MUL_G;
                blend_done = out_free;
            end
            default:
            begin
                mul_sel = MUL_ADDR;
            end
        endcase
    end

    // ---------------- sequencer next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && req_mode == MODE_BLEND)
                    state_next = ST_ADDR;
            end
            ST_ADDR:  state_next = ST_ALPHA;
            ST_ALPHA: state_next = ST_RB;
            ST_RB:    state_next = ST_G;
            ST_G:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- shared multiplier ----------------
    logic [PIXEL_W-1:0] mul_a, mul_p;
    logic [ALPHA_W-1:0] mul_b;
    logic [MASK_VAL_W-1:0] mask_byte;
    logic [7:0]         src_a;
    logic               scale_alpha;
    logic [PIXEL_W-1:0] diff_rb, diff_g;

    assign src_a       = src_reg[ALPHA_POS +: 8];
    assign scale_alpha = use_src_alpha_reg & (src_a != FULL_ALPHA);
    assign diff_rb     = (src_reg & LANES_RB) - (dst_reg & LANES_RB);
    assign diff_g      = (src_reg & LANES_G) - (dst_reg & LANES_G);

    always_comb
    begin
        case (mul_sel)
            MUL_ADDR:
            begin
                mul_a = PIXEL_W'(r_eff);
                mul_b = ALPHA_W'(w_eff);
            end
            MUL_ALPHA:
            begin
                mul_a = PIXEL_W'(mask_byte);
                mul_b = ALPHA_W'(src_a) + ALPHA_W'(src_a[7]);
            end
            MUL_RB:
            begin
                mul_a = diff_rb;
                mul_b = alpha_reg;
            end
            MUL_G:
            begin
                mul_a = diff_g;
                mul_b = alpha_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tmab_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // ---------------- mask store ----------------
    logic              load_we;
    logic              ram_en;
    logic [ADDR_W-1:0] ram_addr;
    logic [ADDR_W-1:0] rd_addr;

    // row * width + column
    assign rd_addr  = ADDR_W'(mul_p) + ADDR_W'(c_eff);
    assign load_we  = req_acc && (req_mode == MODE_LOAD)
                      && (32'(req_idx) < 32'(STORE_DEPTH));
    assign ram_en   = load_we | ram_rd;
    assign ram_addr = ram_rd ? rd_addr : ADDR_W'(req_idx);

    tmab_ram #(
        .WIDTH (MASK_VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (load_we),
        .addr  (ram_addr),
        .wdata (req_val),
        .rdata (mask_byte)
    );

    // ---------------- blend datapath ----------------
    logic [7:0]         alpha_t;
    logic [ALPHA_W-1:0] alpha_next;
    logic [PIXEL_W-1:0] rb_next, g_res;

    always_comb
    begin
        alpha_t    = scale_alpha ? mul_p[15:8] : mask_byte;
        alpha_next = ALPHA_W'(alpha_t) + ALPHA_W'(alpha_t[7]);
        rb_next    = ((dst_reg & LANES_RB) + (mul_p >> 8)) & LANES_RB;
        g_res      = ((dst_reg & LANES_G) + (mul_p >> 8)) & LANES_G;
    end

    // ---------------- rectangle walk ----------------
    logic row_last;

    assign row_last = (32'(cnt_reg) + 32'd1) >= 32'(rw_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        if (req_acc && req_mode == MODE_RESTART)
        begin
            col_next = start_col;
            row_next = start_row;
            cnt_next = '0;
        end
        else if (blend_done)
        begin
            if (row_last)
            begin
                cnt_next = '0;
                col_next = start_col;
                row_next = ((32'(row_reg) + 32'd1) >= 32'(h_eff)) ? '0 : row_reg + COL_W'(1);
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                col_next = ((32'(col_reg) + 32'd1) >= 32'(w_eff)) ? '0 : col_reg + COL_W'(1);
            end
        end
    end

    // ---------------- control registers ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mask_width_reg    <= MASK_SIZE_W'(1);
            mask_height_reg   <= MASK_SIZE_W'(1);
            mask_x0_reg       <= '0;
            mask_y0_reg       <= '0;
            rect_width_reg    <= RECT_W'(1);
            use_src_alpha_reg <= 1'b0;
            col_reg           <= '0;
            row_reg           <= '0;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;

            if (blend_done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MASK_WIDTH:  mask_width_reg    <= cfg_data[MASK_SIZE_W-1:0];
                    CFG_MASK_HEIGHT: mask_height_reg   <= cfg_data[MASK_SIZE_W-1:0];
                    CFG_MASK_X0:     mask_x0_reg       <= cfg_data[MASK_OFS_W-1:0];
                    CFG_MASK_Y0:     mask_y0_reg       <= cfg_data[MASK_OFS_W-1:0];
                    CFG_RECT_WIDTH:  rect_width_reg    <= cfg_data[RECT_W-1:0];
                    CFG_USE_SRC_A:   use_src_alpha_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            src_reg <= req_src;
            dst_reg <= req_dst;
        end
        if (state_reg == ST_ALPHA)
            alpha_reg <= alpha_next;
        if (state_reg == ST_RB)
            rb_reg <= rb_next;
        if (blend_done)
        begin
            out_pixel_reg <= rb_reg | g_res | ALPHA_FORCED;
            out_last_reg  <= row_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ sim/tiled_mask_alpha_blend_core_test.sv @@
// Self-checking testbench for tiled_mask_alpha_blend_core: directed corners, back-pressure
// and random phases, with results checked against an in-bench blend and walk predictor.
// Depends on tmab_pkg and the core RTL only.
`timescale 1ns / 1ps

module tiled_mask_alpha_blend_core_test;
    import tmab_pkg::*;

    localparam int STORE_DEPTH   = MASK_DIM_DEF * MASK_DIM_DEF;
    localparam int BLEND_LATENCY = 4;      // sequencer steps from accept to result valid
    localparam int LONG_HOLD     = 150;    // receiver hold-off, in cycles
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 65;

    logic clk = 1'b0;
    logic rst_n;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIXEL_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // one expected blend result
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
    } blend_result_t;

    blend_result_t pending_results[$];

    // predictor copy of mask tile and registers
    logic [7:0]      tile_mask [0:STORE_DEPTH-1];
    bit              tile_loaded [0:STORE_DEPTH-1];
    logic [6:0]      reg_mask_w;
    logic [6:0]      reg_mask_h;
    logic [5:0]      reg_x0;
    logic [5:0]      reg_y0;
    logic [12:0]     reg_rect_w;
    logic            reg_use_src;
    // walk position
    logic [5:0]      walk_col;
    logic [5:0]      walk_row;
    logic [11:0]     walk_count;

    int unsigned     mismatches;
    bit              idle_on;       // random gaps on both sides
    bit              hold_armed;    // receiver long hold-off request

    tiled_mask_alpha_blend_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // zero counts as 1, oversize saturates
    function automatic int unsigned eff_dim(int unsigned v, int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic int unsigned tile_w();
        return eff_dim(reg_mask_w, MASK_DIM_DEF);
    endfunction

    function automatic int unsigned tile_h();
        return eff_dim(reg_mask_h, MASK_DIM_DEF);
    endfunction

    // offset outside the tile starts at 0
    function automatic int unsigned first_col();
        return (reg_x0 < tile_w()) ? reg_x0 : 0;
    endfunction

    function automatic int unsigned first_row();
        return (reg_y0 < tile_h()) ? reg_y0 : 0;
    endfunction

    // position left outside a shrunk tile reads as 0
    function automatic int unsigned tile_addr();
        int unsigned c;
        int unsigned r;
        c = (walk_col < tile_w()) ? walk_col : 0;
        r = (walk_row < tile_h()) ? walk_row : 0;
        return r * tile_w() + c;
    endfunction

    // 32-bit wraparound lane-pair blend, alpha byte forced
    function automatic logic [PIXEL_W-1:0] blend_argb(logic [PIXEL_W-1:0] s,
                                                      logic [PIXEL_W-1:0] d,
                                                      logic [7:0] m);
        int unsigned        a;
        logic [PIXEL_W-1:0] s_rb;
        logic [PIXEL_W-1:0] d_rb;
        logic [PIXEL_W-1:0] s_g;
        logic [PIXEL_W-1:0] d_g;
        logic [PIXEL_W-1:0] diff;
        logic [PIXEL_W-1:0] prod;
        a = s[31:24];
        if (a == FULL_ALPHA || !reg_use_src)
            a = m;
        else
        begin
            a = a + (a >> 7);
            a = (a * m) >> 8;
        end
        a = a + (a >> 7);
        s_rb = s & LANES_RB;
        d_rb = d & LANES_RB;
        diff = s_rb - d_rb;
        prod = diff * a;
        d_rb = (d_rb + (prod >> 8)) & LANES_RB;
        s_g  = s & LANES_G;
        d_g  = d & LANES_G;
        diff = s_g - d_g;
        prod = diff * a;
        d_g  = (d_g + (prod >> 8)) & LANES_G;
        return d_rb | d_g | ALPHA_FORCED;
    endfunction

    // step the walk after a blended pixel; returns row end
    function automatic logic advance_walk();
        logic last;
        last = (walk_count + 1 >= eff_dim(reg_rect_w, MAX_ROW_DEF));
        if (last)
        begin
            walk_count = '0;
            walk_col   = 6'(first_col());
            walk_row   = 6'((walk_row + 1 >= tile_h()) ? 0 : walk_row + 1);
        end
        else
        begin
            walk_count = walk_count + 12'd1;
            walk_col   = 6'((walk_col + 1 >= tile_w()) ? 0 : walk_col + 1);
        end
        return last;
    endfunction

    function automatic void apply_request(mode_t mode, logic [MASK_IDX_W-1:0] idx,
                                          logic [7:0] val, logic [PIXEL_W-1:0] src,
                                          logic [PIXEL_W-1:0] dst);
        blend_result_t r;
        case (mode)
            MODE_LOAD:
            begin
                tile_mask[idx]   = val;
                tile_loaded[idx] = 1'b1;
            end
            MODE_RESTART:
            begin
                walk_col   = 6'(first_col());
                walk_row   = 6'(first_row());
                walk_count = '0;
            end
            MODE_BLEND:
            begin
                r.pixel   = blend_argb(src, dst, tile_mask[tile_addr()]);
                r.row_end = advance_walk();
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MASK_WIDTH:  reg_mask_w  = val[6:0];
            CFG_MASK_HEIGHT: reg_mask_h  = val[6:0];
            CFG_MASK_X0:     reg_x0      = val[5:0];
            CFG_MASK_Y0:     reg_y0      = val[5:0];
            CFG_RECT_WIDTH:  reg_rect_w  = val[12:0];
            CFG_USE_SRC_A:   reg_use_src = val[0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Random values
    // ---------------------------------------------------------------------

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        logic [PIXEL_W-1:0] p;
        p = $urandom;
        case ($urandom_range(0, 7))
            0: p = 32'hffff_ffff;
            1: p = 32'h0000_0000;
            2: p[31:24] = FULL_ALPHA;
            3: p[31:24] = 8'h00;
            4: p[31:24] = 8'h80;
            5: p[31:24] = 8'h7f;
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Offer one request and hold it until accepted. Valid stays high on return;
    // whoever waits next lowers it.
    task automatic send_req(mode_t mode, logic [MASK_IDX_W-1:0] idx, logic [7:0] val,
                            logic [PIXEL_W-1:0] src, logic [PIXEL_W-1:0] dst);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, dst, src, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        apply_request(mode, idx, val, src, dst);
    endtask

    // blend one pixel; loads the tile entry first if it was never written
    task automatic blend_pixel(logic [PIXEL_W-1:0] src, logic [PIXEL_W-1:0] dst);
        int unsigned addr;
        addr = tile_addr();
        if (!tile_loaded[addr])
            send_req(MODE_LOAD, addr[MASK_IDX_W-1:0], rand_byte(), $urandom, $urandom);
        send_req(MODE_BLEND, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom), src, dst);
    endtask

    // sender pauses until every result is out, then lets the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (BLEND_LATENCY + 4) @(posedge clk);
    endtask

    // write all six registers back to back; only call while idle
    task automatic set_config(int unsigned w, int unsigned h, int unsigned x0,
                              int unsigned y0, int unsigned rw, int unsigned use_a);
        logic [CFG_DATA_W-1:0] vals [6];
        vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(x0),
                 CFG_DATA_W'(y0), CFG_DATA_W'(rw), CFG_DATA_W'(use_a)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_config(cfg_idx_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ---------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_armed = 1'b0;
            end
            else if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------------
    task automatic flag_error(string what, logic [PIXEL_W-1:0] want_v,
                              logic [PIXEL_W-1:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, want_v, got_v, $time);
    endtask

    always @(posedge clk)
    begin : check_results
        blend_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                flag_error("unexpected result", '0, m_tdata);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.pixel)
                    flag_error("result_pixel", want.pixel, m_tdata);
                if (m_tlast !== want.row_end)
                    flag_error("row_end", PIXEL_W'(want.row_end), PIXEL_W'(m_tlast));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // reset register values: 1x1 tile, one-pixel rows, mask alpha only
    task automatic test_reset_defaults();
        send_req(MODE_LOAD, 12'd0, 8'h00, $urandom, $urandom);
        blend_pixel(32'hffff_ffff, 32'h1234_5678);              // zero coverage
        send_req(MODE_LOAD, 12'd0, 8'hff, $urandom, $urandom);
        blend_pixel(32'hffff_ffff, 32'h0000_0000);              // full coverage
        blend_pixel(32'h0000_0000, 32'hffff_ffff);
        send_req(MODE_LOAD, 12'd4095, 8'haa, $urandom, $urandom); // top of store
        send_req(MODE_LOAD, 12'd0, 8'h80, $urandom, $urandom);
        send_req(MODE_NONE, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                 $urandom, $urandom);
        send_req(MODE_RESTART, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                 $urandom, $urandom);
        blend_pixel(32'h80ff_00ff, 32'h00ff_ff00);
    endtask

    // source alpha scaled by mask; row end and tile row wrap
    task automatic test_src_alpha();
        wait_idle();
        set_config(3, 2, 2, 1, 4, 1);
        send_req(MODE_RESTART, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                 $urandom, $urandom);
        blend_pixel(32'hff80_4020, 32'h1020_4080);
        blend_pixel(32'h00ff_ffff, 32'hff00_0000);
        blend_pixel(32'h01ff_00ff, 32'h0000_ff00);
        blend_pixel(32'h7fff_ffff, 32'h0000_0000);
        blend_pixel(32'h80ff_ffff, 32'h0000_0000);
        blend_pixel(32'hfe00_0000, 32'hffff_ffff);
    endtask

    // shrink the tile mid-walk, offsets beyond the tile, zero sizes
    task automatic test_tile_resize();
        wait_idle();
        set_config(2, 1, 5, 3, 3, 0);
        blend_pixel(rand_pixel(), rand_pixel());
        blend_pixel(rand_pixel(), rand_pixel());
        blend_pixel(rand_pixel(), rand_pixel());
        blend_pixel(rand_pixel(), rand_pixel());
        wait_idle();
        set_config(0, 0, 0, 0, 0, 0);
        send_req(MODE_RESTART, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                 $urandom, $urandom);
        blend_pixel(rand_pixel(), rand_pixel());
        blend_pixel(rand_pixel(), rand_pixel());
    endtask

    // receiver holds off while blends keep coming; input must stall
    task automatic test_backpressure();
        wait_idle();
        set_config(5, 3, 1, 2, 6, 1);
        send_req(MODE_RESTART, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                 $urandom, $urandom);
        hold_armed = 1'b1;
        repeat (30)
            blend_pixel(rand_pixel(), rand_pixel());
        wait_idle();
    endtask

    // well-formed row sequences with random content over several settings
    task automatic test_random_phases();
        int unsigned count;
        int unsigned pick;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            idle_on = (p < PHASES - 2);     // last stretch runs without gaps
            case (p)
                0: set_config(64, 64, 63, 63, 4096, 1);
                1: set_config(1, 1, 0, 0, 1, 0);
                2: set_config(0, 127, 5, 63, 0, 1);
                3: set_config(100, 2, 63, 1, 8191, 0);
                default:
                    if ($urandom_range(0, 3) == 0)
                        set_config($urandom_range(0, 127), $urandom_range(0, 127),
                                   $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 8191), $urandom_range(0, 1));
                    else
                        set_config($urandom_range(1, 12), $urandom_range(1, 8),
                                   $urandom_range(0, 15), $urandom_range(0, 10),
                                   $urandom_range(1, 24), $urandom_range(0, 1));
            endcase
            // sometimes keep walking from the old position
            if ($urandom_range(0, 9) < 7)
                send_req(MODE_RESTART, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                         $urandom, $urandom);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 74)
                    blend_pixel(rand_pixel(), rand_pixel());
                else if (pick < 86)
                    send_req(MODE_LOAD,
                             MASK_IDX_W'(($urandom_range(0, 1) != 0) ?
                                 $urandom_range(0, tile_w() * tile_h() - 1) :
                                 $urandom_range(0, STORE_DEPTH - 1)),
                             rand_byte(), $urandom, $urandom);
                else if (pick < 94)
                    send_req(MODE_RESTART, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                             $urandom, $urandom);
                else
                begin
                    // ignored by the block, not counted
                    send_req(MODE_NONE, MASK_IDX_W'($urandom), MASK_VAL_W'($urandom),
                             $urandom, $urandom);
                    continue;
                end
                count++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_NONE;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MASK_WIDTH;
        cfg_data  <= '0;
        mismatches  = 0;
        idle_on     = 1'b1;
        hold_armed  = 1'b0;
        reg_mask_w  = 7'd1;
        reg_mask_h  = 7'd1;
        reg_x0      = '0;
        reg_y0      = '0;
        reg_rect_w  = 13'd1;
        reg_use_src = 1'b0;
        walk_col    = '0;
        walk_row    = '0;
        walk_count  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_src_alpha();
        test_tile_resize();
        test_backpressure();
        test_random_phases();

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin
        #1_600_000;
        $display("simulation failed");
        $finish;
    end

endmodule
